FILE: hw/rtl/relative_change_max_norm_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the relative change max norm block
// Immediate-cycle and next-cycle implication checks on i_clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef RELATIVE_CHANGE_MAX_NORM_TOP_ASSERT_SVH
`define RELATIVE_CHANGE_MAX_NORM_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCMN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RCMN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rcmn_pkg.sv
// ----------------------------------------------------------------------------
// rcmn_pkg
// Shared types and constants of the relative change max norm block.
// ----------------------------------------------------------------------------
package rcmn_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int BAND_W   = 17;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register indexes (paddr[2])
    localparam logic REG_ZERO_BAND = 1'b0;
    localparam logic REG_SENTINEL  = 1'b1;

    localparam logic [BAND_W-1:0] ZERO_BAND_RST = BAND_W'(1);
    localparam logic [DATA_W-1:0] SENTINEL_RST  = DATA_W'(65529446);

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_NORMAL    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BOTH_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OLD_ZERO  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

endpackage

FILE: hw/rtl/rcmn_in_if.sv
// ----------------------------------------------------------------------------
// rcmn_in_if
// Input channel: one new/old value pair per transaction with a last mark.
// ----------------------------------------------------------------------------
interface rcmn_in_if import rcmn_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] new_value;
    logic [DATA_W-1:0] old_value;
    logic              last;

    modport source (output valid, output new_value, output old_value, output last,
                    input ready);
    modport sink   (input valid, input new_value, input old_value, input last,
                    output ready);
endinterface

FILE: hw/rtl/rcmn_out_if.sv
// ----------------------------------------------------------------------------
// rcmn_out_if
// Result channel: maximum relative change of a run and its status code.
// ----------------------------------------------------------------------------
interface rcmn_out_if import rcmn_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   residual_max;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output residual_max, output status, input ready);
    modport sink   (input valid, input residual_max, input status, output ready);
endinterface

FILE: hw/rtl/relative_change_max_norm_top.sv
// ----------------------------------------------------------------------------
// relative_change_max_norm_top
// Convergence check: running max of |(new-old)/old| in Q16.16 over a run.
// ----------------------------------------------------------------------------
//
//   channel  | dir | transaction payload                 | handshake
//   ---------+-----+-------------------------------------+-------------------
//   i_in     | in  | new_value, old_value, last          | valid / ready
//   o_out    | out | residual_max, status                | valid / ready
//   apb      | in  | zero_band @0x0, sentinel_residual @0x4 | psel/penable
//
// An ordinary pair goes from one acceptance to the next through capture,
// magnitude, range check, 32 steps of the shared restoring divider, update.
// Ready rises again when the sequencer returns to idle after the update.
// Zero-band pairs and saturating quotients skip the divider and go from the range check to the update.
// The divider (one 32-bit subtract and compare per cycle) sets the rate.
// Reset is synchronous, active low; it clears control state and the running
// max/status, and loads the register reset values.
// A last pair waits in its update cycle while the result register is full.
// ----------------------------------------------------------------------------
module relative_change_max_norm_top import rcmn_pkg::*; #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rcmn_in_if.sink             i_in,
    rcmn_out_if.source          o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

`include "relative_change_max_norm_top_assert.svh"

    // Values are sign extended from bit EFF_W-1 of the 32-bit field.
    localparam int EFF_W = (VALUE_WIDTH > DATA_W) ? DATA_W : VALUE_WIDTH;
    localparam int SH    = DATA_W - EFF_W;

    function automatic logic signed [DATA_W-1:0] f_sext(input logic [DATA_W-1:0] raw);
        logic [DATA_W-1:0] up;
        up = raw << SH;
        return signed'(up) >>> SH;
    endfunction

    function automatic logic [DATA_W-1:0] f_abs(input logic signed [DATA_W:0] v);
        logic [DATA_W:0] m;
        m = v[DATA_W] ? ((DATA_W+1)'(0) - (DATA_W+1)'(v)) : (DATA_W+1)'(v);
        return m[DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BAND_W-1:0] r_zero_band;
    logic [DATA_W-1:0] r_sentinel;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_SENTINEL) ? r_sentinel
                                                 : PDATA_W'(r_zero_band);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_band <= ZERO_BAND_RST;
            r_sentinel  <= SENTINEL_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_ZERO_BAND: r_zero_band <= pwdata[BAND_W-1:0];
                REG_SENTINEL:  r_sentinel  <= pwdata;
                default:       r_sentinel  <= r_sentinel;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    t_state                     r_state, n_state;
    logic signed [DATA_W-1:0]   r_nv, n_nv;       // sign-extended new value
    logic signed [DATA_W-1:0]   r_ov, n_ov;       // sign-extended old value
    logic                       r_last, n_last;
    logic [DATA_W-1:0]          r_num, n_num;     // |new - old|
    logic [DATA_W-1:0]          r_den, n_den;     // |old|, divisor
    logic [DATA_W-1:0]          r_nmag, n_nmag;   // |new|
    logic [DATA_W-1:0]          r_rem, n_rem;     // partial remainder
    logic [DATA_W-1:0]          r_lo, n_lo;       // dividend bits in, quotient out
    logic [4:0]                 r_cnt, n_cnt;     // divider steps left after this one
    logic [DATA_W-1:0]          r_max, n_max;
    logic [STATUS_W-1:0]        r_status, n_status;
    logic                       r_out_valid, n_out_valid;
    logic [DATA_W-1:0]          r_out_max, n_out_max;
    logic [STATUS_W-1:0]        r_out_status, n_out_status;

    logic                       w_out_free;
    logic                       w_old_zero;
    logic                       w_new_zero;
    logic                       w_ovf;
    logic [BAND_W-1:0]          w_band;
    logic [2*DATA_W-1:0]        w_dividend;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_band     = (r_zero_band == '0) ? BAND_W'(1) : r_zero_band;
    assign w_old_zero = r_den  < DATA_W'(w_band);
    assign w_new_zero = r_nmag < DATA_W'(w_band);
    // Dividend is |new-old| scaled by 2^FRAC_BITS; the quotient fits in
    // 32 bits exactly when its upper word is below the divisor.
    assign w_dividend = (2*DATA_W)'(r_num) << FRAC_BITS;
    assign w_ovf      = w_dividend[2*DATA_W-1:DATA_W] >= r_den;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_PREP;
            end
            S_PREP: n_state = S_CHECK;
            S_CHECK: begin
                if (w_old_zero || w_ovf) n_state = S_DONE;
                else                     n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_DONE;
            end
            S_DONE: begin
                // Hold a last pair until the result register frees up.
                if (!r_last || w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        logic [DATA_W-1:0] trial;
        logic [DATA_W-1:0] upd_max;

        n_nv         = r_nv;
        n_ov         = r_ov;
        n_last       = r_last;
        n_num        = r_num;
        n_den        = r_den;
        n_nmag       = r_nmag;
        n_rem        = r_rem;
        n_lo         = r_lo;
        n_cnt        = r_cnt;
        n_max        = r_max;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_max    = r_out_max;
        n_out_status = r_out_status;

        trial   = {r_rem[DATA_W-2:0], r_lo[DATA_W-1]};
        upd_max = (r_lo > r_max) ? r_lo : r_max;

        case (r_state)
            S_IDLE: begin
                n_nv   = f_sext(i_in.new_value);
                n_ov   = f_sext(i_in.old_value);
                n_last = i_in.last;
            end
            S_PREP: begin
                n_num  = f_abs({r_nv[DATA_W-1], r_nv} - {r_ov[DATA_W-1], r_ov});
                n_den  = f_abs({r_ov[DATA_W-1], r_ov});
                n_nmag = f_abs({r_nv[DATA_W-1], r_nv});
            end
            S_CHECK: begin
                n_cnt = 5'd31;
                if (w_old_zero) begin
                    if (w_new_zero) begin
                        n_lo     = '0;
                        n_status = STATUS_BOTH_ZERO;
                    end else begin
                        n_lo     = r_sentinel;
                        n_status = STATUS_OLD_ZERO;
                    end
                end else if (w_ovf) begin
                    n_lo = '1;
                end else begin
                    n_rem = w_dividend[2*DATA_W-1:DATA_W];
                    n_lo  = w_dividend[DATA_W-1:0];
                end
            end
            S_DIV: begin
                // One restoring step: shift in a dividend bit, try subtract.
                n_cnt = r_cnt - 5'd1;
                if (trial >= r_den) begin
                    n_rem = trial - r_den;
                    n_lo  = {r_lo[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem = trial;
                    n_lo  = {r_lo[DATA_W-2:0], 1'b0};
                end
            end
            S_DONE: begin
                if (!r_last) begin
                    n_max = upd_max;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_max    = upd_max;
                    n_out_status = r_status;
                    n_max        = '0;
                    n_status     = STATUS_NORMAL;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.residual_max = r_out_max;
    assign o_out.status       = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= '0;
            r_status    <= STATUS_NORMAL;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_max       <= n_max;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nv         <= n_nv;
        r_ov         <= n_ov;
        r_last       <= n_last;
        r_num        <= n_num;
        r_den        <= n_den;
        r_nmag       <= n_nmag;
        r_rem        <= n_rem;
        r_lo         <= n_lo;
        r_out_max    <= n_out_max;
        r_out_status <= n_out_status;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RCMN_ASSERT_NOW(a_div_rem_bound, r_state == S_DIV, r_rem < r_den,
        "divider remainder reached the divisor")
    `RCMN_ASSERT_NEXT(a_div_exit, (r_state == S_DIV) && (r_cnt == '0), r_state == S_DONE,
        "divider did not finish after its last step")
    `RCMN_ASSERT_NOW(a_out_from_done, $rose(r_out_valid),
        ($past(r_state) == S_DONE) && $past(r_last),
        "result raised outside the update of a last pair")
    `RCMN_ASSERT_NEXT(a_clear_after_emit, (r_state == S_DONE) && r_last && w_out_free,
        (r_max == '0) && (r_status == STATUS_NORMAL),
        "running max or status not cleared after a run")

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Relative change max norm testbench
// Streams runs of new/old Q16.16 pairs through the convergence check, folds
// each accepted pair into a local model of the running maximum and status,
// and checks every emitted result field by field. Configuration is changed
// over APB between drained phases, and both handshake sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import rcmn_pkg::*;

    localparam int VALUE_W         = 32;
    localparam int FRAC            = 16;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 240;
    // Longest divider pass plus some margin; covers pairs that make no result.
    localparam int SETTLE_CYCLES   = 48;

    typedef struct packed {
        logic [DATA_W-1:0] new_value;
        logic [DATA_W-1:0] old_value;
        logic              last;
    } t_pair;

    typedef struct packed {
        logic [DATA_W-1:0]   residual_max;
        logic [STATUS_W-1:0] status;
    } t_norm;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    rcmn_in_if  in_ch ();
    rcmn_out_if out_ch ();

    relative_change_max_norm_top #(
        .VALUE_WIDTH (VALUE_W),
        .FRAC_BITS   (FRAC)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Pairs waiting for the driver, and norms waiting for the result channel.
    t_pair pending_pairs [$];
    t_norm expected_norms [$];

    // Shadow of the configuration registers and of the block's run state.
    logic [BAND_W-1:0]   cfg_band;
    logic [DATA_W-1:0]   cfg_sentinel;
    logic [DATA_W-1:0]   run_max;
    logic [STATUS_W-1:0] run_status;

    int    errors;
    bit    idling_on;
    int    calm_left;
    int    send_gap;
    int    stall_left;
    bit    in_taken;
    t_norm folded;
    t_norm oldest;

    // ------------------------------------------------------------------------
    // Model of one pair: relative change |(new-old)/old| in unsigned Q16.16,
    // truncated and saturated, folded into the running max. An old value
    // inside the zero band bypasses the division and sets the status code.
    // Return 1 with the emitted norm when the pair closes a run.
    // ------------------------------------------------------------------------
    function automatic bit fold_pair(input t_pair p, output t_norm norm_out);
        logic signed [63:0] nv;
        logic signed [63:0] ov;
        logic signed [63:0] diff;
        logic [63:0]        band;
        logic [63:0]        old_mag;
        logic [63:0]        new_mag;
        logic [63:0]        diff_mag;
        logic [63:0]        quot;
        logic [DATA_W-1:0]  change;
        nv       = $signed(p.new_value);
        ov       = $signed(p.old_value);
        diff     = nv - ov;
        band     = (cfg_band == '0) ? 64'd1 : 64'(cfg_band);
        old_mag  = (ov < 0) ? -ov : ov;
        new_mag  = (nv < 0) ? -nv : nv;
        diff_mag = (diff < 0) ? -diff : diff;
        if (old_mag < band) begin
            if (new_mag < band) begin
                change     = '0;
                run_status = STATUS_BOTH_ZERO;
            end else begin
                change     = cfg_sentinel;
                run_status = STATUS_OLD_ZERO;
            end
        end else begin
            quot   = (diff_mag << FRAC) / old_mag;
            change = (quot > 64'hFFFF_FFFF) ? '1 : quot[DATA_W-1:0];
        end
        if (change > run_max) begin
            run_max = change;
        end
        norm_out = '{residual_max: run_max, status: run_status};
        if (p.last) begin
            run_max    = '0;
            run_status = STATUS_NORMAL;
        end
        return p.last;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus value pickers.
    // ------------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] edge_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0001;
            4: return 32'h0001_0000;
            default: return 32'hFFFF_0000;
        endcase
    endfunction

    // Magnitudes around the zero band edge, either sign.
    function automatic logic [DATA_W-1:0] band_word();
        int unsigned       eff;
        logic [DATA_W-1:0] m;
        eff = (cfg_band == '0) ? 1 : int'(cfg_band);
        if ($urandom_range(0, 2) == 0) begin
            m = eff - 1 + $urandom_range(0, 2);
        end else begin
            m = $urandom_range(0, eff + 2);
        end
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic logic [DATA_W-1:0] old_word();
        logic [DATA_W-1:0] m;
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return band_word();
            3:       return edge_word();
            4, 5:    return $urandom();
            default: begin
                m = $urandom_range(1, 32'h00FF_FFFF) >> $urandom_range(0, 16);
                return $urandom_range(0, 1) ? -m : m;
            end
        endcase
    endfunction

    // Mostly a small step away from the old value, as a converging solver gives.
    function automatic logic [DATA_W-1:0] new_word(input logic [DATA_W-1:0] prev);
        logic signed [DATA_W-1:0] step;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return band_word();
            2:       return edge_word();
            3:       return $urandom();
            default: begin
                step = $urandom();
                step = step >>> $urandom_range(4, 31);
                return prev + step;
            end
        endcase
    endfunction

    task automatic queue_pair(input logic [DATA_W-1:0] nv, input logic [DATA_W-1:0] ov,
                              input logic last);
        pending_pairs.push_back('{new_value: nv, old_value: ov, last: last});
    endtask

    // ------------------------------------------------------------------------
    // APB access: setup cycle, then access cycle until pready.
    // ------------------------------------------------------------------------
    task automatic cfg_write(input logic reg_sel, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (reg_sel == REG_ZERO_BAND) begin
            cfg_band = data[BAND_W-1:0];
        end else begin
            cfg_sentinel = data[DATA_W-1:0];
        end
    endtask

    task automatic cfg_check(input logic reg_sel, input logic [PDATA_W-1:0] want_data);
        logic [PDATA_W-1:0] got_data;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {reg_sel, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got_data = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got_data !== want_data) begin
            $display("%0t: register %0d readback expected %h, got %h",
                     $time, reg_sel, want_data, got_data);
            errors++;
        end
    endtask

    // Hold until every queued pair is taken and every norm has come back,
    // then let the divider finish any pair that makes no result.
    task automatic wait_for_idle();
        while (pending_pairs.size() != 0 || in_ch.valid || expected_norms.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present pairs from the pending queue at the falling edge. Keep a
    // pair on the bus until its transaction completes; insert random idle
    // bursts between transactions while idling is enabled.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap    <= 0;
        end else if (!in_ch.valid || in_taken) begin
            if (send_gap != 0) begin
                in_ch.valid <= 1'b0;
                send_gap    <= send_gap - 1;
            end else if (pending_pairs.size() != 0 && idling_on && calm_left == 0 &&
                         $urandom_range(0, 7) == 0) begin
                in_ch.valid <= 1'b0;
                send_gap    <= $urandom_range(1, 18) - 1;
            end else if (pending_pairs.size() != 0) begin
                in_ch.valid     <= 1'b1;
                in_ch.new_value <= pending_pairs[0].new_value;
                in_ch.old_value <= pending_pairs[0].old_value;
                in_ch.last      <= pending_pairs[0].last;
                void'(pending_pairs.pop_front());
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink: drop ready for random bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (idling_on && calm_left == 0 && $urandom_range(0, 11) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(1, 18) - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Open occasional stretches with no idling on either side.
    always @(negedge i_clk) begin
        if (calm_left != 0) begin
            calm_left <= calm_left - 1;
        end else if ($urandom_range(0, 999) == 0) begin
            calm_left <= $urandom_range(100, 400);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: on every accepted input transaction advance the model; on every
    // accepted result transaction compare against the oldest expected norm.
    // Inputs first, so a same-edge result can never see a stale queue.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            if (fold_pair('{new_value: in_ch.new_value, old_value: in_ch.old_value,
                            last: in_ch.last}, folded)) begin
                expected_norms.push_back(folded);
            end
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_norms.size() == 0) begin
                $display("%0t: unexpected result, expected none, got residual_max %h status %0d",
                         $time, out_ch.residual_max, out_ch.status);
                errors++;
            end else begin
                oldest = expected_norms.pop_front();
                if (out_ch.residual_max !== oldest.residual_max) begin
                    $display("%0t: residual_max expected %h, got %h",
                             $time, oldest.residual_max, out_ch.residual_max);
                    errors++;
                end
                if (out_ch.status !== oldest.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, oldest.status, out_ch.status);
                    errors++;
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, register defaults, directed pairs, then random runs
    // over several register settings. Every phase drains fully before the
    // next configuration write, which also forces the sender to pause until
    // all outstanding results are back.
    // ------------------------------------------------------------------------
    initial begin
        logic [BAND_W-1:0] band_plan     [PHASES];
        logic [DATA_W-1:0] sentinel_plan [PHASES];
        logic [DATA_W-1:0] ov;
        int                queued;
        int                run_len;

        // Drive every input to a known value from time zero.
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.new_value = '0;
        in_ch.old_value = '0;
        in_ch.last      = 1'b0;
        out_ch.ready    = 1'b0;
        errors          = 0;
        idling_on       = 1'b1;
        calm_left       = 0;
        in_taken        = 1'b0;
        cfg_band        = ZERO_BAND_RST;
        cfg_sentinel    = SENTINEL_RST;
        run_max         = '0;
        run_status      = STATUS_NORMAL;

        // A band of 65536 with zero sentinel, band of zero with full sentinel, random
        // settings, narrowest band, then a small random band; the last phase runs flat out.
        band_plan[0]     = BAND_W'(65536);
        sentinel_plan[0] = '0;
        band_plan[1]     = '0;
        sentinel_plan[1] = '1;
        band_plan[2]     = BAND_W'($urandom_range(1, 65536));
        sentinel_plan[2] = $urandom();
        band_plan[3]     = BAND_W'(1);
        sentinel_plan[3] = $urandom();
        band_plan[4]     = BAND_W'($urandom_range(1, 300));
        sentinel_plan[4] = SENTINEL_RST;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        cfg_check(REG_ZERO_BAND, PDATA_W'(ZERO_BAND_RST));
        cfg_check(REG_SENTINEL, PDATA_W'(SENTINEL_RST));

        // Directed pairs under the reset configuration.
        queue_pair(32'h0000_0000, 32'h0000_0000, 1'b1); // both in band
        queue_pair(32'h0000_0005, 32'h0000_0000, 1'b1); // old in band only
        queue_pair(32'h0001_8000, 32'h0001_0000, 1'b1); // plain 0.5
        queue_pair(32'h0000_0001, 32'h0000_0003, 1'b1); // truncated quotient
        queue_pair(32'h0001_0000, 32'h0003_0000, 1'b1);
        queue_pair(32'hFFFF_0000, 32'h0001_0000, 1'b1); // sign flip
        queue_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b1); // old of -1 LSB
        queue_pair(32'h8000_0000, 32'h0000_0001, 1'b1); // saturates
        queue_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1); // widest difference
        queue_pair(32'h8000_0000, 32'h8000_0000, 1'b1);
        queue_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        // Status follows the most recent special case; max survives it.
        queue_pair(32'h0000_0003, 32'h0000_0000, 1'b0);
        queue_pair(32'h0002_0000, 32'h0001_0000, 1'b0);
        queue_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
        queue_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_pair(32'h0003_0000, 32'h0001_0000, 1'b1);
        queue_pair(32'h0001_0000, 32'h0001_0000, 1'b0);
        queue_pair(32'h0001_4000, 32'h0001_0000, 1'b1);
        wait_for_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            cfg_write(REG_ZERO_BAND, PDATA_W'(band_plan[ph]));
            cfg_write(REG_SENTINEL, PDATA_W'(sentinel_plan[ph]));
            cfg_check(REG_ZERO_BAND, PDATA_W'(band_plan[ph]));
            cfg_check(REG_SENTINEL, PDATA_W'(sentinel_plan[ph]));
            idling_on = (ph != PHASES - 1);

            // Exact zeros first, which matters most with a band of zero.
            queue_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
            queue_pair(32'h0000_0001, 32'h0000_0000, 1'b1);

            queued = 0;
            while (queued < ITEMS_PER_PHASE) begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                      : $urandom_range(1, 8);
                for (int k = 0; k < run_len; k++) begin
                    ov = old_word();
                    queue_pair(new_word(ov), ov, k == run_len - 1);
                end
                queued += run_len;
            end
            wait_for_idle();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rcmn_pkg.sv
hw/rtl/rcmn_in_if.sv
hw/rtl/rcmn_out_if.sv
hw/rtl/relative_change_max_norm_top.sv
bench/testbench.sv
